// File: hdl/kwm_pkg.sv
// kwm_pkg: shared constants and types for the k-way sorted merge.
// Used by k_way_sorted_merge and its bench. No dependencies.
package kwm_pkg;

	localparam int NUM_LISTS_DEF  = 4;
	localparam int LIST_DEPTH_DEF = 16;
	localparam int DATA_W         = 32;
	localparam int IDX_W          = 2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_MERGE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_WAIT,
		ST_PICK
	} kwm_state_t;

endpackage

// File: hdl/kwm_ram.sv
// kwm_ram: generic single-write, single-read synchronous RAM, registered read.
// No package dependency.
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/k_way_sorted_merge.sv
// k_way_sorted_merge: top level of the k-way merge by smallest head.
// Depends on kwm_pkg and kwm_ram.

// Merges up to NUM_LISTS ascending lists of signed 32-bit values into one
// stream. A load request (action = 0) appends value to list list_index; it
// is dropped when that list already holds LIST_DEPTH values or the index is
// not a list of this build. busy stays low while idle, so loads may follow
// one another every cycle. A merge request (action = 1) raises busy and
// emits every stored value, smallest current head first, lower list index
// first on equal values. Each result shows on value_res, source_list and
// last_of_run for exactly one cycle with strobe high; the receiver cannot
// stall, so it must take every strobe. A merge runs through ST_FILL, which
// fetches the first element of each list in turn, then ST_WAIT, which lets
// the last fetch land; each result then takes an ST_PICK and an ST_WAIT,
// and a closing ST_PICK empties all lists. Results cannot come back to back
// because the element store has a single read port with a registered read:
// the next element of the list just popped must be fetched before the next
// comparison can run.
module k_way_sorted_merge #(
	parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
	parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [kwm_pkg::IDX_W-1:0]        list_index,
	input  logic signed [kwm_pkg::DATA_W-1:0] value,
	output logic                             strobe,
	output logic signed [kwm_pkg::DATA_W-1:0] value_res,
	output logic [kwm_pkg::IDX_W-1:0]        source_list,
	output logic                             last_of_run
);

	import kwm_pkg::*;

	localparam int STORE_SIZE = NUM_LISTS * LIST_DEPTH;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int LIST_W     = $clog2(NUM_LISTS);
	localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

	// control state
	kwm_state_t          state_q, state_d;
	logic [LEN_W-1:0]    len_q        [NUM_LISTS];
	logic [LEN_W-1:0]    pos_q        [NUM_LISTS];
	logic                head_valid_q [NUM_LISTS];
	logic [LIST_W-1:0]   fill_q;
	logic                rd_pending_q;
	logic [LIST_W-1:0]   rd_list_q;
	logic                strobe_q;

	// head register per list: the element at that list's read position
	logic signed [DATA_W-1:0] head_q [NUM_LISTS];

	// output payload
	logic signed [DATA_W-1:0] value_res_q;
	logic [IDX_W-1:0]         source_list_q;
	logic                     last_q;

	// element store port
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	// load path
	logic [LIST_W-1:0]   ld_list;
	logic                ld_ok;
	logic                accept;

	// head selection
	logic                     found;
	logic [LIST_W-1:0]        best;
	logic signed [DATA_W-1:0] best_val;
	logic                     other_valid;
	logic [LEN_W-1:0]         best_next_pos;
	logic                     next_more;

	function automatic logic [ADDR_W-1:0] list_base(input logic [LIST_W-1:0] lst);
		return ADDR_W'(lst) * ADDR_W'(LIST_DEPTH);
	endfunction

	assign accept  = start && (state_q == ST_IDLE);
	assign ld_list = LIST_W'(list_index);
	// out-of-range index short-circuits before the length is looked at
	assign ld_ok   = (32'(list_index) < NUM_LISTS) && (32'(len_q[ld_list]) < LIST_DEPTH);
	assign ram_waddr = list_base(ld_list) + ADDR_W'(len_q[ld_list]);

	// smallest valid head; strict compare keeps the lower index on a tie
	always_comb begin
		found    = 1'b0;
		best     = '0;
		best_val = '0;
		for (int i = 0; i < NUM_LISTS; i++) begin
			if (head_valid_q[i] && (!found || (head_q[i] < best_val))) begin
				found    = 1'b1;
				best     = LIST_W'(i);
				best_val = head_q[i];
			end
		end
		other_valid = 1'b0;
		for (int i = 0; i < NUM_LISTS; i++) begin
			if (head_valid_q[i] && (LIST_W'(i) != best)) begin
				other_valid = 1'b1;
			end
		end
		best_next_pos = pos_q[best] + LEN_W'(1);
		next_more     = best_next_pos < len_q[best];
	end

	// next state and store control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_LOAD) begin
						ram_we = ld_ok;
					end else begin
						state_d = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				ram_re    = (len_q[fill_q] != '0);
				ram_raddr = list_base(fill_q);
				if (32'(fill_q) == NUM_LISTS - 1) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (found) begin
					ram_re    = next_more;
					ram_raddr = list_base(best) + ADDR_W'(best_next_pos);
					state_d   = ST_WAIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			rd_pending_q <= 1'b0;
			rd_list_q    <= '0;
			strobe_q     <= 1'b0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				len_q[i]        <= '0;
				pos_q[i]        <= '0;
				head_valid_q[i] <= 1'b0;
			end
		end else begin
			state_q      <= state_d;
			rd_pending_q <= ram_re;
			strobe_q     <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					fill_q <= '0;
					if (accept && (action == ACT_LOAD) && ld_ok) begin
						len_q[ld_list] <= len_q[ld_list] + LEN_W'(1);
					end
				end
				ST_FILL: begin
					pos_q[fill_q]        <= '0;
					head_valid_q[fill_q] <= (len_q[fill_q] != '0);
					rd_list_q            <= fill_q;
					fill_q               <= fill_q + LIST_W'(1);
				end
				ST_PICK: begin
					if (found) begin
						strobe_q           <= 1'b1;
						pos_q[best]        <= best_next_pos;
						head_valid_q[best] <= next_more;
						rd_list_q          <= best;
					end else begin
						// run finished: every list empties
						for (int i = 0; i < NUM_LISTS; i++) begin
							len_q[i]        <= '0;
							head_valid_q[i] <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// fetched element passes through the store's read register into its list's head register
	always_ff @(posedge clk) begin
		if (rd_pending_q) begin
			head_q[rd_list_q] <= ram_rdata;
		end
		if ((state_q == ST_PICK) && found) begin
			value_res_q   <= best_val;
			source_list_q <= IDX_W'(best);
			last_q        <= !next_more && !other_valid;
		end
	end

	kwm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy        = (state_q != ST_IDLE);
	assign strobe      = strobe_q;
	assign value_res   = value_res_q;
	assign source_list = source_list_q;
	assign last_of_run = last_q;

endmodule

// File: sim/tb_k_way_sorted_merge.sv
// tb_k_way_sorted_merge: self-checking bench for the k-way sorted merge.
// Loads lists, merges them and checks every result against an in-bench model.
// Depends on kwm_pkg and the k_way_sorted_merge RTL.
module tb_k_way_sorted_merge;
	import kwm_pkg::*;

	localparam int NUM_LISTS    = NUM_LISTS_DEF;
	localparam int LIST_DEPTH   = LIST_DEPTH_DEF;
	localparam int MAX_RESULTS  = NUM_LISTS * LIST_DEPTH;
	localparam int CLK_PERIOD   = 8;
	localparam int RANDOM_ITEMS = 250;
	// merge of a full store, plus margin
	localparam int DRAIN_CYCLES = NUM_LISTS + 2 * MAX_RESULTS + 16;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic [IDX_W-1:0]         src;
		logic                     last;
	} merged_elem_t;

	// Mirror of the list store; a merge request expands into the queue of
	// elements the block must emit, smallest head first, lower list on ties.
	class merge_scoreboard;
		logic signed [DATA_W-1:0] store [NUM_LISTS][LIST_DEPTH];
		int unsigned              fill [NUM_LISTS];
		merged_elem_t             pending [$];
		int                       errors;

		function void note_request(input logic act, input logic [IDX_W-1:0] idx,
				input logic signed [DATA_W-1:0] v);
			int unsigned              pos [NUM_LISTS];
			int unsigned              total;
			int                       best;
			logic signed [DATA_W-1:0] best_v;
			bit                       found;
			merged_elem_t             elem;
			if (act == ACT_LOAD) begin
				// full list or absent list: request dropped
				if (idx < NUM_LISTS && fill[idx] < LIST_DEPTH) begin
					store[idx][fill[idx]] = v;
					fill[idx]++;
				end
				return;
			end
			total = 0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				pos[i] = 0;
				total += fill[i];
			end
			for (int unsigned n = 0; n < total; n++) begin
				found  = 1'b0;
				best   = 0;
				best_v = '0;
				for (int i = 0; i < NUM_LISTS; i++) begin
					if (pos[i] < fill[i] && (!found || store[i][pos[i]] < best_v)) begin
						found  = 1'b1;
						best   = i;
						best_v = store[i][pos[i]];
					end
				end
				elem.val  = best_v;
				elem.src  = best[IDX_W-1:0];
				elem.last = (n + 1 == total);
				pending.insert(pending.size(), elem);
				pos[best]++;
			end
			for (int i = 0; i < NUM_LISTS; i++)
				fill[i] = 0;
		endfunction

		function void check_result(input logic signed [DATA_W-1:0] val,
				input logic [IDX_W-1:0] src, input logic last);
			merged_elem_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result value %0d list %0d last %0b",
					$time, val, src, last);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (val !== exp.val) begin
				$display("%0t: value_res expected %0d got %0d", $time, exp.val, val);
				errors++;
			end
			if (src !== exp.src) begin
				$display("%0t: source_list expected %0d got %0d", $time, exp.src, src);
				errors++;
			end
			if (last !== exp.last) begin
				$display("%0t: last_of_run expected %0b got %0b", $time, exp.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic                     action     = ACT_LOAD;
	logic [IDX_W-1:0]         list_index = '0;
	logic signed [DATA_W-1:0] value      = '0;
	logic                     busy;
	logic                     strobe;
	logic signed [DATA_W-1:0] value_res;
	logic [IDX_W-1:0]         source_list;
	logic                     last_of_run;

	merge_scoreboard sb;
	int              items_sent = 0;
	int              cycles     = 0;
	bit              no_gaps    = 1'b0;

	k_way_sorted_merge #(
		.NUM_LISTS (NUM_LISTS),
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.list_index (list_index),
		.value      (value),
		.strobe     (strobe),
		.value_res  (value_res),
		.source_list(source_list),
		.last_of_run(last_of_run)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// results cannot be held off: take every strobe
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(value_res, source_list, last_of_run);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still awaited", $time, sb.pending.size());
			$display("tb_k_way_sorted_merge: FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called just after a rising edge. start stays high when the next
	// request follows straight on, so it is never lowered and raised in one step.
	task automatic send_request(input logic act, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] v);
		int gap;
		start      <= 1'b1;
		action     <= act;
		list_index <= idx;
		value      <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(act, idx, v);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One fill-then-merge sequence. Most lists are ascending with random
	// content; some passes use a narrow value range to force ties, some load
	// unsorted data, and some overfill a list past its depth.
	task automatic run_merge_pass();
		int                       left [NUM_LISTS];
		logic signed [DATA_W-1:0] cur [NUM_LISTS];
		logic signed [DATA_W-1:0] v;
		longint                   nv;
		bit                       sorted;
		bit                       tight;
		int                       r;
		int                       sel;
		int                       remaining;
		sorted    = ($urandom_range(0, 9) != 0);
		tight     = ($urandom_range(0, 3) == 0);
		no_gaps   = ($urandom_range(0, 4) == 0);
		remaining = 0;
		for (int i = 0; i < NUM_LISTS; i++) begin
			r = $urandom_range(0, 9);
			if (r < 1)
				left[i] = 0;
			else if (r < 8)
				left[i] = $urandom_range(1, 6);
			else
				left[i] = $urandom_range(7, LIST_DEPTH + 3);
			remaining += left[i];
			if (tight)
				cur[i] = $urandom_range(0, 6) - 3;
			else
				cur[i] = $urandom;
		end
		while (remaining > 0) begin
			do
				sel = $urandom_range(0, NUM_LISTS - 1);
			while (left[sel] == 0);
			if (!sorted)
				v = tight ? $urandom_range(0, 6) - 3 : $urandom;
			else begin
				v  = cur[sel];
				nv = longint'(cur[sel]) + (tight ? $urandom_range(0, 1)
					: $urandom_range(0, 1 << 20));
				if (nv > 64'sd2147483647)
					nv = 64'sd2147483647;
				cur[sel] = nv[DATA_W-1:0];
			end
			send_request(ACT_LOAD, sel[IDX_W-1:0], v);
			left[sel]--;
			remaining--;
		end
		// index and value carry junk on a merge
		send_request(ACT_MERGE, IDX_W'($urandom), $urandom);
		// occasionally a back-to-back merge with every list already empty
		if ($urandom_range(0, 7) == 0)
			send_request(ACT_MERGE, IDX_W'($urandom), $urandom);
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: merge of an empty store, extreme values, a tie on zero
		// between lists 1 and 2, an unsorted list 3 and list 2 overfilled
		// by one so its last load is dropped.
		send_request(ACT_MERGE, 2'd3, 32'sd0);
		send_request(ACT_LOAD, 2'd3, 32'sh8000_0000);
		send_request(ACT_LOAD, 2'd0, 32'sh7fff_ffff);
		send_request(ACT_LOAD, 2'd1, -32'sd1);
		send_request(ACT_LOAD, 2'd1, 32'sd0);
		for (int k = 0; k <= LIST_DEPTH; k++)
			send_request(ACT_LOAD, 2'd2, k * 1000);
		send_request(ACT_LOAD, 2'd3, 32'sd5);
		send_request(ACT_LOAD, 2'd3, -32'sd5);
		send_request(ACT_MERGE, 2'd0, 32'sh5555_aaaa);

		while (items_sent < RANDOM_ITEMS)
			run_merge_pass();
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
			sb.errors++;
		end

		if (sb.errors == 0)
			$display("tb_k_way_sorted_merge: PASS");
		else
			$display("tb_k_way_sorted_merge: FAIL");
		$finish;
	end

endmodule
